// ----- src/rwc_pkg.sv -----
// Shared types and constants for the RGB window convolution block.
// Used by every module in src; depends on nothing.
package rwc_pkg;

    localparam int KERNEL_SIDE = 8;
    localparam int LINES       = KERNEL_SIDE - 1;
    localparam int KIDX_BITS   = 3;
    localparam int CH_BITS     = 16;
    localparam int PIX_BITS    = 3 * CH_BITS;
    localparam int SUM_BITS    = 32;
    localparam int TAG_BITS    = 10;
    localparam int MIN_WIDTH   = 8;
    localparam int PRODS       = 3 * KERNEL_SIDE;
    localparam int GROUPS      = 3;
    localparam int GROUP_SIZE  = PRODS / GROUPS;

    localparam logic CMD_KERNEL = 1'b0;
    localparam logic CMD_PIXEL  = 1'b1;

    typedef logic [PIX_BITS-1:0] pixel_t;
    typedef pixel_t [LINES-1:0] line_word_t;
    typedef pixel_t [KERNEL_SIDE-1:0] column_t;

    typedef struct packed {
        logic                 we;
        logic [KIDX_BITS-1:0] row;
        pixel_t               rgb;
    } kernel_load_t;

    typedef struct packed {
        logic en;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] col;
        logic [TAG_BITS-1:0] row;
        logic [SUM_BITS-1:0] sum;
    } out_item_t;

endpackage

// ----- src/rgb_window_convolution_8x8.sv -----
// Top level of the streaming 8x8 RGB convolution over a square image.
// Depends on rwc_pkg, rwc_line_mem, rwc_cell and rwc_out_fifo.
//
// The block takes one transaction per cycle: kernel loads (tuser 0) and image pixels (tuser 1)
// in raster order. A pixel whose row and column are both at least 7 yields one sum, tagged
// with the window's top-left corner, which is registered and queued before it is offered on
// the result channel. The sustained rate of one pixel per cycle is set by the column line
// memory, which can be read at one column and written at another in the same cycle, and by the
// row of eight cells that each hold one window column and hand it to their neighbor. A sum
// always uses the kernel as loaded before its pixel. A two-entry output queue lets the
// input keep flowing while a result waits to be taken; while it is full the input is held off.
module rgb_window_convolution_8x8 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kernel_index[5:0], red_value[21:6], green_value[37:22], blue_value[53:38], zeros.
    input  logic [55:0] s_tdata,
    // command.
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sum_value[31:0], out_row[41:32], out_col[51:42], zeros.
    output logic [55:0] m_tdata
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int KS = rwc_pkg::KERNEL_SIDE;
    localparam int TB = rwc_pkg::TAG_BITS;
    localparam int SB = rwc_pkg::SUM_BITS;

    logic en, acc, is_pix, is_kern, fifo_full, emit, last_col, last_row;
    logic [WW-1:0] width_reg, width_next;
    logic [AW-1:0] row_reg, col_reg, col_cur;
    logic [rwc_pkg::KIDX_BITS-1:0] k_row, k_col;
    rwc_pkg::pixel_t px;

    logic s1_pix_reg, s2_pix_reg, s3_pix_reg, s4_pix_reg;
    logic s1_emit_reg, s2_emit_reg, s3_emit_reg, s4_emit_reg;
    logic [TB-1:0] s1_row_reg, s2_row_reg, s3_row_reg, s4_row_reg;
    logic [TB-1:0] s1_col_reg, s2_col_reg, s3_col_reg, s4_col_reg;
    logic [AW-1:0] s1_addr_reg;
    rwc_pkg::pixel_t s1_px_reg;

    rwc_pkg::line_word_t rd_data, wr_data;
    rwc_pkg::column_t col_vec;
    rwc_pkg::column_t col_chain [KS];
    rwc_pkg::cell_ctrl_t ctl;
    rwc_pkg::out_item_t push_item, out_item;
    logic [SB-1:0] p_cell [KS];
    logic [SB-1:0] sum_total;

    assign en       = !fifo_full;
    assign s_tready = en;
    assign acc      = s_tvalid && en;
    assign is_pix   = acc && (s_tuser == rwc_pkg::CMD_PIXEL);
    assign is_kern  = acc && (s_tuser == rwc_pkg::CMD_KERNEL);
    assign k_col    = s_tdata[rwc_pkg::KIDX_BITS-1:0];
    assign k_row    = s_tdata[2*rwc_pkg::KIDX_BITS-1:rwc_pkg::KIDX_BITS];
    assign px       = s_tdata[53:6];

    always_comb begin
        if (32'(cfg_wr_data) > 32'(MAX_WIDTH)) begin
            width_next = WW'(MAX_WIDTH);
        end else if (32'(cfg_wr_data) < 32'(rwc_pkg::MIN_WIDTH)) begin
            width_next = WW'(rwc_pkg::MIN_WIDTH);
        end else begin
            width_next = WW'(cfg_wr_data);
        end
        col_cur  = (WW'(col_reg) >= width_reg) ? '0 : col_reg;
        last_col = (WW'(col_cur) + WW'(1)) >= width_reg;
        last_row = (WW'(row_reg) + WW'(1)) >= width_reg;
        emit     = (WW'(row_reg) >= WW'(rwc_pkg::LINES)) && (WW'(col_cur) >= WW'(rwc_pkg::LINES));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WW'(rwc_pkg::MIN_WIDTH);
            row_reg   <= '0;
            col_reg   <= '0;
        end else if (cfg_wr_en) begin
            width_reg <= width_next;
            row_reg   <= '0;
            col_reg   <= '0;
        end else if (is_pix) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + AW'(1);
            end else begin
                col_reg <= col_cur + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_pix_reg <= 1'b0;
            s2_pix_reg <= 1'b0;
            s3_pix_reg <= 1'b0;
            s4_pix_reg <= 1'b0;
        end else if (en) begin
            s1_pix_reg <= is_pix;
            s2_pix_reg <= s1_pix_reg;
            s3_pix_reg <= s2_pix_reg;
            s4_pix_reg <= s3_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_emit_reg <= emit;
            s1_row_reg  <= TB'(row_reg - AW'(rwc_pkg::LINES));
            s1_col_reg  <= TB'(col_cur - AW'(rwc_pkg::LINES));
            s1_addr_reg <= col_cur;
            s1_px_reg   <= px;
            s2_emit_reg <= s1_emit_reg;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s3_emit_reg <= s2_emit_reg;
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            s4_emit_reg <= s3_emit_reg;
            s4_row_reg  <= s3_row_reg;
            s4_col_reg  <= s3_col_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < rwc_pkg::LINES - 1; k++) begin
            wr_data[k] = rd_data[k+1];
        end
        wr_data[rwc_pkg::LINES-1] = s1_px_reg;
        for (int k = 0; k < rwc_pkg::LINES; k++) begin
            col_vec[k] = rd_data[k];
        end
        col_vec[KS-1] = s1_px_reg;
    end

    rwc_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (is_pix),
        .rd_addr (col_cur),
        .rd_data (rd_data),
        .wr_en   (en && s1_pix_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    assign ctl.en    = en;
    assign ctl.shift = en && s1_pix_reg;

    genvar gi;
    generate
        for (gi = 0; gi < KS; gi++) begin : g_cell
            rwc_pkg::kernel_load_t kld;
            assign kld.we  = is_kern && (k_col == rwc_pkg::KIDX_BITS'(gi));
            assign kld.row = k_row;
            assign kld.rgb = px;
            if (gi == KS - 1) begin : g_last
                rwc_cell u_cell (
                    .aclk    (aclk),
                    .ctl     (ctl),
                    .kld     (kld),
                    .col_in  (col_vec),
                    .col_out (col_chain[gi]),
                    .p_out   (p_cell[gi])
                );
            end else begin : g_link
                rwc_cell u_cell (
                    .aclk    (aclk),
                    .ctl     (ctl),
                    .kld     (kld),
                    .col_in  (col_chain[gi+1]),
                    .col_out (col_chain[gi]),
                    .p_out   (p_cell[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        sum_total = '0;
        for (int k = 0; k < KS; k++) begin
            sum_total = sum_total + p_cell[k];
        end
    end

    assign push_item.sum = sum_total;
    assign push_item.row = s4_row_reg;
    assign push_item.col = s4_col_reg;

    rwc_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && s4_pix_reg && s4_emit_reg),
        .push_data (push_item),
        .full      (fifo_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_item)
    );

    assign m_tdata = {4'd0, out_item.col, out_item.row, out_item.sum};

endmodule

// ----- src/rwc_line_mem.sv -----
// Column-organized line memory: one word per image column holding the last rows.
// Depends on rwc_pkg.
module rwc_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output rwc_pkg::line_word_t rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  rwc_pkg::line_word_t wr_data
);

    rwc_pkg::line_word_t mem [DEPTH];
    rwc_pkg::line_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/rwc_cell.sv -----
// One window column of the convolution chain: its pixels, its kernel column and its share
// of the sum. Depends on rwc_pkg.
module rwc_cell (
    input  logic                         aclk,
    input  rwc_pkg::cell_ctrl_t          ctl,
    input  rwc_pkg::kernel_load_t        kld,
    input  rwc_pkg::column_t             col_in,
    output rwc_pkg::column_t             col_out,
    output logic [rwc_pkg::SUM_BITS-1:0] p_out
);

    localparam int CB = rwc_pkg::CH_BITS;
    localparam int SB = rwc_pkg::SUM_BITS;

    rwc_pkg::pixel_t kern_reg [rwc_pkg::KERNEL_SIDE];
    rwc_pkg::column_t win_reg;
    logic [SB-1:0] prod_reg [rwc_pkg::PRODS];
    logic [SB-1:0] prod_next [rwc_pkg::PRODS];
    logic [SB-1:0] grp_reg [rwc_pkg::GROUPS];
    logic [SB-1:0] grp_next [rwc_pkg::GROUPS];
    logic [SB-1:0] p_reg, p_next;

    always_comb begin
        for (int k = 0; k < rwc_pkg::KERNEL_SIDE; k++) begin
            for (int ch = 0; ch < 3; ch++) begin
                prod_next[3*k+ch] = SB'(col_in[k][ch*CB +: CB]) * SB'(kern_reg[k][ch*CB +: CB]);
            end
        end
        for (int g = 0; g < rwc_pkg::GROUPS; g++) begin
            grp_next[g] = '0;
            for (int i = 0; i < rwc_pkg::GROUP_SIZE; i++) begin
                grp_next[g] = grp_next[g] + prod_reg[g*rwc_pkg::GROUP_SIZE+i];
            end
        end
        p_next = grp_reg[0] + grp_reg[1] + grp_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (kld.we) begin
            kern_reg[kld.row] <= kld.rgb;
        end
        if (ctl.shift) begin
            win_reg <= col_in;
        end
        if (ctl.en) begin
            prod_reg <= prod_next;
            grp_reg  <= grp_next;
            p_reg    <= p_next;
        end
    end

    assign col_out = win_reg;
    assign p_out   = p_reg;

endmodule

// ----- src/rwc_out_fifo.sv -----
// Two-entry output queue that decouples the result stream from the pipeline.
// Depends on rwc_pkg.
module rwc_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rwc_pkg::out_item_t push_data,
    output logic               full,
    output logic               m_valid,
    input  logic               m_ready,
    output rwc_pkg::out_item_t m_data
);

    rwc_pkg::out_item_t e0_reg, e1_reg;
    logic [1:0] cnt_reg;
    logic pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = cnt_reg != 2'd0;
    assign full    = cnt_reg == 2'd2;
    assign m_data  = e0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            unique case ({push, pop})
                2'b10: cnt_reg <= cnt_reg + 2'd1;
                2'b01: cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case ({push, pop})
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    e0_reg <= push_data;
                end else begin
                    e1_reg <= push_data;
                end
            end
            2'b01: begin
                e0_reg <= e1_reg;
            end
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    e0_reg <= push_data;
                end else begin
                    e0_reg <= e1_reg;
                    e1_reg <= push_data;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
